/* rtl/core/pa4x_pkg.sv */
package pa4x_pkg;

    typedef logic [23:0] pix_t;

    typedef enum logic [2:0] {
        RULE_NONE,
        RULE_SQUARE,
        RULE_HSLOPE,
        RULE_VSLOPE,
        RULE_DIAG
    } rule_t;

    typedef struct packed {
        pix_t [8:0]  c;
        rule_t [3:0] code;
        logic        last;
    } job_t;

    localparam logic [3:0] ROT_C [0:3][0:7] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7},
        '{4'd6, 4'd3, 4'd0, 4'd7, 4'd4, 4'd1, 4'd8, 4'd5},
        '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1},
        '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd0, 4'd3}
    };

    localparam logic [3:0] ROT_E [0:3][0:15] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd12, 4'd8, 4'd4, 4'd0, 4'd13, 4'd9, 4'd5, 4'd1,
          4'd14, 4'd10, 4'd6, 4'd2, 4'd15, 4'd11, 4'd7, 4'd3},
        '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
          4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
        '{4'd3, 4'd7, 4'd11, 4'd15, 4'd2, 4'd6, 4'd10, 4'd14,
          4'd1, 4'd5, 4'd9, 4'd13, 4'd0, 4'd4, 4'd8, 4'd12}
    };

    // (3a+b)/4 per channel, truncated
    function automatic pix_t blend31(input pix_t a, input pix_t b);
        pix_t       r;
        logic [9:0] s;
        for (int ch = 0; ch < 3; ch++)
        begin
            s = 10'({2'b00, a[ch*8 +: 8]}) * 10'd3 + 10'({2'b00, b[ch*8 +: 8]});
            r[ch*8 +: 8] = s[9:2];
        end
        return r;
    endfunction

    // (a+b)/2 per channel, truncated
    function automatic pix_t blend11(input pix_t a, input pix_t b);
        pix_t       r;
        logic [8:0] s;
        for (int ch = 0; ch < 3; ch++)
        begin
            s = {1'b0, a[ch*8 +: 8]} + {1'b0, b[ch*8 +: 8]};
            r[ch*8 +: 8] = s[8:1];
        end
        return r;
    endfunction

    function automatic rule_t classify(input pix_t [8:0] c, input logic [1:0] rot);
        pix_t  a, b, cc, d, e, f, g, h;
        rule_t r;
        a  = c[ROT_C[rot][0]];
        b  = c[ROT_C[rot][1]];
        cc = c[ROT_C[rot][2]];
        d  = c[ROT_C[rot][3]];
        e  = c[ROT_C[rot][4]];
        f  = c[ROT_C[rot][5]];
        g  = c[ROT_C[rot][6]];
        h  = c[ROT_C[rot][7]];
        if (b == e || d == e || d != b)
            r = RULE_NONE;
        else if (b == cc && d == g)
            r = (a != e) ? RULE_SQUARE : RULE_NONE;
        else if (b == cc && cc != f)
            r = RULE_HSLOPE;
        else if (d == g && g != h)
            r = RULE_VSLOPE;
        else
            r = RULE_DIAG;
        return r;
    endfunction

    function automatic pix_t [15:0] apply_rule(input pix_t [8:0] c, input pix_t [15:0] e,
                                               input logic [1:0] rot, input rule_t code);
        logic [3:0]  x [16];
        pix_t        d;
        pix_t [15:0] r;
        for (int k = 0; k < 16; k++)
            x[k] = ROT_E[rot][k];
        d = c[ROT_C[rot][3]];
        r = e;
        case (code)
            RULE_SQUARE:
            begin
                r[x[0]]  = d;
                r[x[1]]  = d;
                r[x[2]]  = blend31(d, e[x[2]]);
                r[x[3]]  = blend31(e[x[3]], d);
                r[x[4]]  = d;
                r[x[8]]  = blend31(d, e[x[8]]);
                r[x[12]] = blend31(e[x[12]], d);
                r[x[5]]  = blend11(d, e[x[5]]);
            end
            RULE_HSLOPE:
            begin
                r[x[0]] = d;
                r[x[1]] = d;
                r[x[2]] = blend31(d, e[x[2]]);
                r[x[3]] = blend31(e[x[3]], d);
                r[x[4]] = blend31(d, e[x[4]]);
                r[x[5]] = blend31(e[x[5]], d);
            end
            RULE_VSLOPE:
            begin
                r[x[0]]  = d;
                r[x[4]]  = d;
                r[x[8]]  = blend31(d, e[x[8]]);
                r[x[12]] = blend31(e[x[12]], d);
                r[x[1]]  = blend31(d, e[x[1]]);
                r[x[5]]  = blend31(e[x[5]], d);
            end
            RULE_DIAG:
            begin
                r[x[0]] = d;
                r[x[1]] = blend11(d, e[x[1]]);
                r[x[4]] = blend11(d, e[x[4]]);
            end
            default:
            begin
                r = e;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/pa4x_in_if.sv */
interface pa4x_in_if;
    logic            valid;
    logic            ready;
    pa4x_pkg::pix_t  pix_above;
    pa4x_pkg::pix_t  pix_centre;
    pa4x_pkg::pix_t  pix_below;
    logic            row_end;

    modport source (output valid, output pix_above, output pix_centre, output pix_below,
                    output row_end, input ready);
    modport sink (input valid, input pix_above, input pix_centre, input pix_below,
                  input row_end, output ready);
endinterface

/* rtl/core/pa4x_out_if.sv */
interface pa4x_out_if;
    logic            valid;
    logic            ready;
    logic [1:0]      sub_row;
    pa4x_pkg::pix_t  out_px0;
    pa4x_pkg::pix_t  out_px1;
    pa4x_pkg::pix_t  out_px2;
    pa4x_pkg::pix_t  out_px3;
    logic            run_last;

    modport source (output valid, output sub_row, output out_px0, output out_px1,
                    output out_px2, output out_px3, output run_last, input ready);
    modport sink (input valid, input sub_row, input out_px0, input out_px1,
                  input out_px2, input out_px3, input run_last, output ready);
endinterface

/* rtl/core/pixel_art_4x_edge_scaler.sv */
// 4x edge-directed pixel-art upscaler. Each item on col_in is one source column (pixels of the
// rows above, at and below the current row, plus row_end); blk_out returns the 4x4 block of a
// centre pixel as four items, sub-rows 0 to 3, the last one flagged by run_last (except in the
// block of the column before a row_end column). Output runs one column behind input: the first
// column of a row yields nothing unless it is also row_end, every later column yields the block
// of the column before it, and a row_end column also flushes its own block (eight items; the
// front holds the second job in a pending register). The block engine applies one rotation of
// the edge rule per cycle, the last rotation waiting for a free output buffer, and then streams
// four sub-rows from an output buffer while the next block is computed. A small job queue
// between the column window and the block engine lets input and output stall independently.
module pixel_art_4x_edge_scaler #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    pa4x_in_if.sink     col_in,
    pa4x_out_if.source  blk_out
);

    logic               q_wr_valid, q_wr_ready;
    pa4x_pkg::job_t     q_wr_job;
    logic               q_rd_valid, q_rd_ready;
    pa4x_pkg::job_t     q_rd_job;

    pa4x_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .col_in   (col_in),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_job   (q_wr_job)
    );

    pa4x_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_job   (q_wr_job),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_job   (q_rd_job)
    );

    pa4x_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_job   (q_rd_job),
        .blk_out  (blk_out)
    );

    a_last_on_final_row: assert property (@(posedge clk) disable iff (!rst_n)
        blk_out.valid && blk_out.run_last |-> blk_out.sub_row == 2'd3)
        else $error("run_last on a sub-row other than the last");

    a_sub_row_steps: assert property (@(posedge clk) disable iff (!rst_n)
        blk_out.valid && blk_out.ready && blk_out.sub_row != 2'd3
        |=> blk_out.valid && blk_out.sub_row == $past(blk_out.sub_row) + 2'd1)
        else $error("sub-row sequence broken inside a block");

    a_queue_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        col_in.valid && col_in.ready |-> q_wr_ready)
        else $error("column taken while the job queue is full");

endmodule

/* rtl/core/pa4x_front.sv */
module pa4x_front (
    input  logic                clk,
    input  logic                rst_n,
    pa4x_in_if.sink             col_in,
    output logic                wr_valid,
    input  logic                wr_ready,
    output pa4x_pkg::job_t      wr_job
);

    logic                   held_reg, held_next;
    logic                   pend_valid_reg, pend_valid_next;
    pa4x_pkg::job_t         pend_job_reg, pend_job_next;
    pa4x_pkg::pix_t [2:0]   left_reg, left_next;
    pa4x_pkg::pix_t [2:0]   mid_reg, mid_next;
    pa4x_pkg::pix_t [2:0]   col;
    pa4x_pkg::job_t         job;
    logic                   accept;

    function automatic pa4x_pkg::job_t make_job(input pa4x_pkg::pix_t [2:0] lf,
                                                input pa4x_pkg::pix_t [2:0] md,
                                                input pa4x_pkg::pix_t [2:0] rt,
                                                input logic last);
        pa4x_pkg::job_t j;
        for (int i = 0; i < 3; i++)
        begin
            j.c[3*i]     = lf[i];
            j.c[3*i + 1] = md[i];
            j.c[3*i + 2] = rt[i];
        end
        for (int r = 0; r < 4; r++)
            j.code[r] = pa4x_pkg::RULE_NONE;
        j.last = last;
        return j;
    endfunction

    assign col[0] = col_in.pix_above;
    assign col[1] = col_in.pix_centre;
    assign col[2] = col_in.pix_below;

    assign col_in.ready = !pend_valid_reg && wr_ready;
    assign accept       = col_in.valid && col_in.ready;

    always_comb
    begin
        held_next       = held_reg;
        pend_valid_next = pend_valid_reg;
        pend_job_next   = pend_job_reg;
        left_next       = left_reg;
        mid_next        = mid_reg;
        wr_valid        = 1'b0;
        job             = make_job(col, col, col, 1'b1);
        if (pend_valid_reg)
        begin
            wr_valid = 1'b1;
            job      = pend_job_reg;
            if (wr_ready)
                pend_valid_next = 1'b0;
        end
        else if (accept)
        begin
            if (!held_reg)
            begin
                if (col_in.row_end)
                begin
                    wr_valid = 1'b1;
                    job      = make_job(col, col, col, 1'b1);
                end
                else
                begin
                    left_next = col;
                    mid_next  = col;
                    held_next = 1'b1;
                end
            end
            else
            begin
                wr_valid = 1'b1;
                if (col_in.row_end)
                begin
                    job             = make_job(left_reg, mid_reg, col, 1'b0);
                    pend_job_next   = make_job(mid_reg, col, col, 1'b1);
                    pend_valid_next = 1'b1;
                    held_next       = 1'b0;
                end
                else
                begin
                    job       = make_job(left_reg, mid_reg, col, 1'b1);
                    left_next = mid_reg;
                    mid_next  = col;
                end
            end
        end
        wr_job = job;
        for (int r = 0; r < 4; r++)
            wr_job.code[r] = pa4x_pkg::classify(job.c, 2'(r));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg       <= held_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_job_reg <= pend_job_next;
        left_reg     <= left_next;
        mid_reg      <= mid_next;
    end

endmodule

/* rtl/core/pa4x_queue.sv */
module pa4x_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  pa4x_pkg::job_t      wr_job,
    output logic                rd_valid,
    input  logic                rd_ready,
    output pa4x_pkg::job_t      rd_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pa4x_pkg::job_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

/* rtl/core/pa4x_back.sv */
module pa4x_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_valid,
    output logic                rd_ready,
    input  pa4x_pkg::job_t      rd_job,
    pa4x_out_if.source          blk_out
);

    logic                   busy_reg, busy_next;
    logic [1:0]             rot_reg, rot_next;
    pa4x_pkg::job_t         job_reg, job_next;
    pa4x_pkg::pix_t [15:0]  e_reg, e_next, e_rot;
    logic                   obuf_valid_reg, obuf_valid_next;
    pa4x_pkg::pix_t [15:0]  obuf_reg, obuf_next;
    logic                   olast_reg, olast_next;
    logic [1:0]             sub_reg, sub_next;
    logic                   out_take, obuf_free, can_move, pop;

    assign e_rot     = pa4x_pkg::apply_rule(job_reg.c, e_reg, rot_reg, job_reg.code[rot_reg]);
    assign out_take  = obuf_valid_reg && blk_out.ready;
    assign obuf_free = !obuf_valid_reg || (out_take && sub_reg == 2'd3);
    assign can_move  = busy_reg && rot_reg == 2'd3 && obuf_free;
    assign pop       = rd_valid && (!busy_reg || can_move);
    assign rd_ready  = !busy_reg || can_move;

    always_comb
    begin
        busy_next       = busy_reg;
        rot_next        = rot_reg;
        job_next        = job_reg;
        e_next          = e_reg;
        obuf_valid_next = obuf_valid_reg;
        obuf_next       = obuf_reg;
        olast_next      = olast_reg;
        sub_next        = sub_reg;

        if (out_take)
        begin
            sub_next = sub_reg + 1'b1;
            if (sub_reg == 2'd3)
                obuf_valid_next = 1'b0;
        end

        if (busy_reg && rot_reg != 2'd3)
        begin
            e_next   = e_rot;
            rot_next = rot_reg + 1'b1;
        end

        if (can_move)
        begin
            obuf_next       = e_rot;
            olast_next      = job_reg.last;
            obuf_valid_next = 1'b1;
            sub_next        = 2'd0;
            busy_next       = 1'b0;
        end

        if (pop)
        begin
            job_next  = rd_job;
            e_next    = {16{rd_job.c[4]}};
            rot_next  = 2'd0;
            busy_next = 1'b1;
        end
    end

    assign blk_out.valid    = obuf_valid_reg;
    assign blk_out.sub_row  = sub_reg;
    assign blk_out.out_px0  = obuf_reg[{sub_reg, 2'd0}];
    assign blk_out.out_px1  = obuf_reg[{sub_reg, 2'd1}];
    assign blk_out.out_px2  = obuf_reg[{sub_reg, 2'd2}];
    assign blk_out.out_px3  = obuf_reg[{sub_reg, 2'd3}];
    assign blk_out.run_last = olast_reg && sub_reg == 2'd3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            rot_reg        <= 2'd0;
            obuf_valid_reg <= 1'b0;
            sub_reg        <= 2'd0;
        end
        else
        begin
            busy_reg       <= busy_next;
            rot_reg        <= rot_next;
            obuf_valid_reg <= obuf_valid_next;
            sub_reg        <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        e_reg     <= e_next;
        obuf_reg  <= obuf_next;
        olast_reg <= olast_next;
    end

endmodule

/* verif/tb_top.sv */
module tb_top;
    typedef pa4x_pkg::pix_t pix_t;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 330;
    localparam int MAX_REPORTS  = 100;
    localparam int DRAIN_CYCLES = 20;

    localparam pix_t CX = 24'h123456;
    localparam pix_t CY = 24'hA0B0C0;
    localparam pix_t CZ = 24'h00FF00;
    localparam pix_t CW = 24'h0000FF;

    typedef struct packed {
        pix_t above;
        pix_t centre;
        pix_t below;
        logic row_end;
    } column_t;

    typedef struct packed {
        logic [1:0] sub_row;
        pix_t [3:0] px;
        logic       run_last;
    } sub_row_t;

    logic    clk     = 1'b0;
    logic    rst_n   = 1'b0;
    logic    c_valid = 1'b0;
    column_t c_item  = '0;
    logic    b_ready = 1'b0;

    column_t    col_q [$];
    sub_row_t   block_q [$];
    pix_t [2:0] left_col    = '0;
    pix_t [2:0] mid_col     = '0;
    logic       col_pending = 1'b0;
    logic       col_taken   = 1'b0;
    logic       calm        = 1'b0;
    int         err_cnt     = 0;
    int         idle_cnt    = 0;
    int         in_gap      = 0;
    int         out_gap     = 0;
    int         cyc         = 0;
    sub_row_t   want;

    pa4x_in_if  col_if ();
    pa4x_out_if blk_if ();

    assign col_if.valid      = c_valid;
    assign col_if.pix_above  = c_item.above;
    assign col_if.pix_centre = c_item.centre;
    assign col_if.pix_below  = c_item.below;
    assign col_if.row_end    = c_item.row_end;
    assign blk_if.ready      = b_ready;

    pixel_art_4x_edge_scaler u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .col_in  (col_if),
        .blk_out (blk_if)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // position of a 3x3 or 4x4 grid cell after rot quarter turns
    function automatic int turn(int pos, int rot, int n);
        int r;
        int c;
        int t;
        r = pos / n;
        c = pos % n;
        for (int k = 0; k < rot; k++)
        begin
            t = r;
            r = n - 1 - c;
            c = t;
        end
        return r * n + c;
    endfunction

    function automatic pix_t mix31(pix_t a, pix_t b);
        pix_t r;
        for (int ch = 0; ch < 3; ch++)
            r[ch*8 +: 8] = 8'((3 * int'(a[ch*8 +: 8]) + int'(b[ch*8 +: 8])) >> 2);
        return r;
    endfunction

    function automatic pix_t mix11(pix_t a, pix_t b);
        pix_t r;
        for (int ch = 0; ch < 3; ch++)
            r[ch*8 +: 8] = 8'((int'(a[ch*8 +: 8]) + int'(b[ch*8 +: 8])) >> 1);
        return r;
    endfunction

    function automatic pix_t [15:0] edge_rule(pix_t [8:0] nb, pix_t [15:0] e, int rot);
        pix_t a, b, c, d, m, f, g, h;
        int   x [16];
        for (int k = 0; k < 16; k++)
            x[k] = turn(k, rot, 4);
        a = nb[turn(0, rot, 3)];
        b = nb[turn(1, rot, 3)];
        c = nb[turn(2, rot, 3)];
        d = nb[turn(3, rot, 3)];
        m = nb[turn(4, rot, 3)];
        f = nb[turn(5, rot, 3)];
        g = nb[turn(6, rot, 3)];
        h = nb[turn(7, rot, 3)];
        if (b == m || d == m || d != b)
            return e;
        if (b == c && d == g)
        begin
            // square
            if (a != m)
            begin
                e[x[0]]  = d;
                e[x[1]]  = d;
                e[x[2]]  = mix31(d, e[x[2]]);
                e[x[3]]  = mix31(e[x[3]], d);
                e[x[4]]  = d;
                e[x[8]]  = mix31(d, e[x[8]]);
                e[x[12]] = mix31(e[x[12]], d);
                e[x[5]]  = mix11(d, e[x[5]]);
            end
        end
        else if (b == c && c != f)
        begin
            e[x[0]] = d;
            e[x[1]] = d;
            e[x[2]] = mix31(d, e[x[2]]);
            e[x[3]] = mix31(e[x[3]], d);
            e[x[4]] = mix31(d, e[x[4]]);
            e[x[5]] = mix31(e[x[5]], d);
        end
        else if (d == g && g != h)
        begin
            e[x[0]]  = d;
            e[x[4]]  = d;
            e[x[8]]  = mix31(d, e[x[8]]);
            e[x[12]] = mix31(e[x[12]], d);
            e[x[1]]  = mix31(d, e[x[1]]);
            e[x[5]]  = mix31(e[x[5]], d);
        end
        else
        begin
            e[x[0]] = d;
            e[x[1]] = mix11(d, e[x[1]]);
            e[x[4]] = mix11(d, e[x[4]]);
        end
        return e;
    endfunction

    task automatic emit_block(pix_t [2:0] lf, pix_t [2:0] md, pix_t [2:0] rt,
                              logic mark_last);
        pix_t [8:0]  nb;
        pix_t [15:0] blk;
        sub_row_t    s;
        for (int i = 0; i < 3; i++)
        begin
            nb[3*i]     = lf[i];
            nb[3*i + 1] = md[i];
            nb[3*i + 2] = rt[i];
        end
        blk = {16{md[1]}};
        for (int rot = 0; rot < 4; rot++)
            blk = edge_rule(nb, blk, rot);
        for (int k = 0; k < 4; k++)
        begin
            s.sub_row = 2'(k);
            for (int j = 0; j < 4; j++)
                s.px[j] = blk[4*k + j];
            s.run_last = mark_last && (k == 3);
            block_q.push_back(s);
        end
    endtask

    task automatic predict_column(column_t c);
        pix_t [2:0] col;
        col = {c.below, c.centre, c.above};
        if (!col_pending)
        begin
            left_col    = col;
            mid_col     = col;
            col_pending = 1'b1;
        end
        else
        begin
            emit_block(left_col, mid_col, col, !c.row_end);
            left_col = mid_col;
            mid_col  = col;
        end
        if (c.row_end)
        begin
            emit_block(left_col, mid_col, mid_col, 1'b1);
            left_col    = '0;
            mid_col     = '0;
            col_pending = 1'b0;
        end
    endtask

    task automatic check_field(string name, logic [23:0] exp_val, logic [23:0] got);
        if (exp_val !== got)
        begin
            if (err_cnt < MAX_REPORTS)
                $error("%s: expected %0h, got %0h", name, exp_val, got);
            err_cnt++;
        end
    endtask

    function automatic int gap_len();
        int p;
        if (calm)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pix_t rand_color();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return 24'h000000;
        if (p == 1)
            return 24'hFFFFFF;
        return 24'($urandom);
    endfunction

    function automatic pix_t pick_px(pix_t [2:0] pal, int span, bit wild);
        if (wild || $urandom_range(0, 19) == 0)
            return rand_color();
        return pal[$urandom_range(0, span - 1)];
    endfunction

    task automatic add_col(pix_t a, pix_t m, pix_t b, logic last);
        column_t c;
        c.above   = a;
        c.centre  = m;
        c.below   = b;
        c.row_end = last;
        col_q.push_back(c);
    endtask

    task automatic wait_drain();
        while (col_q.size() != 0 || c_valid || block_q.size() != 0)
            @(negedge clk);
    endtask

    // item driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            cyc++;
            if (cyc % 256 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (!c_valid || col_taken)
            begin
                col_taken = 1'b0;
                if (in_gap > 0)
                begin
                    in_gap--;
                    c_valid <= 1'b0;
                end
                else if (col_q.size() > 0)
                begin
                    c_item  <= col_q.pop_front();
                    c_valid <= 1'b1;
                    in_gap = gap_len();
                end
                else
                begin
                    c_valid <= 1'b0;
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                b_ready <= 1'b0;
            end
            else
            begin
                b_ready <= 1'b1;
                out_gap = gap_len();
            end
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cnt++;
            if (c_valid && col_if.ready)
            begin
                predict_column(c_item);
                col_taken = 1'b1;
                idle_cnt  = 0;
            end
            if (blk_if.valid && b_ready)
            begin
                idle_cnt = 0;
                if (block_q.size() == 0)
                begin
                    if (err_cnt < MAX_REPORTS)
                        $error("sub-row item with none expected");
                    err_cnt++;
                end
                else
                begin
                    want = block_q.pop_front();
                    check_field("sub_row", 24'(want.sub_row), 24'(blk_if.sub_row));
                    check_field("out_px0", want.px[0], blk_if.out_px0);
                    check_field("out_px1", want.px[1], blk_if.out_px1);
                    check_field("out_px2", want.px[2], blk_if.out_px2);
                    check_field("out_px3", want.px[3], blk_if.out_px3);
                    check_field("run_last", 24'(want.run_last), 24'(blk_if.run_last));
                end
            end
            if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        pix_t [2:0] pal;
        int         sent;
        int         len;
        int         span;
        int         r;
        bit         wild;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // one-pixel row, then a two-column row
        add_col(24'h000000, 24'hFFFFFF, 24'h000000, 1'b1);
        add_col(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0);
        add_col(24'h000000, 24'h000000, 24'h000000, 1'b1);
        // square
        add_col(CZ, CX, CX, 1'b0);
        add_col(CX, CY, CW, 1'b0);
        add_col(CX, CW, CW, 1'b1);
        // square blocked by corner equal to centre
        add_col(CY, CX, CX, 1'b0);
        add_col(CX, CY, CW, 1'b0);
        add_col(CX, CW, CW, 1'b1);
        // horizontal slope
        add_col(CZ, CX, CZ, 1'b0);
        add_col(CX, CY, CW, 1'b0);
        add_col(CX, CW, CW, 1'b1);
        // vertical slope
        add_col(CZ, CX, CX, 1'b0);
        add_col(CX, CY, CW, 1'b0);
        add_col(CW, CW, CW, 1'b1);
        // pure diagonal
        add_col(CZ, CX, CZ, 1'b0);
        add_col(CX, CY, CW, 1'b0);
        add_col(CW, CW, CW, 1'b1);
        wait_drain();

        for (int ph = 0; ph < 2; ph++)
        begin
            sent = 0;
            while (sent < RANDOM_ITEMS / 2)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    len = 1;
                else if (r < 7)
                    len = $urandom_range(2, 6);
                else if (r < 9)
                    len = $urandom_range(7, 12);
                else
                    len = $urandom_range(13, 24);
                wild = ($urandom_range(0, 7) == 0);
                span = $urandom_range(2, 3);
                for (int k = 0; k < 3; k++)
                    pal[k] = rand_color();
                for (int k = 0; k < len; k++)
                    add_col(pick_px(pal, span, wild), pick_px(pal, span, wild),
                            pick_px(pal, span, wild), k == len - 1);
                sent += len;
            end
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (err_cnt == 0 && block_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/pa4x_pkg.sv
rtl/core/pa4x_in_if.sv
rtl/core/pa4x_out_if.sv
rtl/core/pa4x_front.sv
rtl/core/pa4x_queue.sv
rtl/core/pa4x_back.sv
rtl/core/pixel_art_4x_edge_scaler.sv
verif/tb_top.sv
